@@ rtl/lrd_pkg.sv @@
`default_nettype none

package lrd_pkg;

    // Pixel channel width and the widths of the result fields.
    localparam int PIX_W    = 8;
    localparam int TOP_W    = 12;
    localparam int BOT_W    = 11;
    localparam int BRIGHT_W = 8;

    // A channel mean never exceeds 255, so each quotient has 8 bits.
    localparam int QUO_W  = 8;
    localparam int QBIT_W = 3;

    // The sum of three quotients is at most 765.
    localparam int TOTAL_W = 10;

    // Division by three as (x * 683) >> 11, exact for every x up to 765.
    localparam int PROD_W     = 20;
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_ADD,
        BK_MUL,
        BK_UPD
    } bk_state_t;

    typedef struct packed {
        logic                    top_found;
        logic signed [TOP_W-1:0] top_row;
        logic                    bottom_found;
        logic [BOT_W-1:0]        bottom_row;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/lrd_fifo.sv @@
`default_nettype none

module lrd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lrd_front.sv @@
`default_nettype none

module lrd_front #(
    parameter int MAX_COLS = 4096
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [lrd_pkg::PIX_W-1:0]   blue,
    input  wire logic [lrd_pkg::PIX_W-1:0]   green,
    input  wire logic [lrd_pkg::PIX_W-1:0]   red,
    input  wire logic                        row_end,
    input  wire logic                        frame_end,
    output logic                             rec_push,
    output logic [3*($clog2(MAX_COLS+1)+lrd_pkg::PIX_W)+$clog2(MAX_COLS+1):0] rec_data
);

    localparam int CNT_W = $clog2(MAX_COLS + 1);
    localparam int SUM_W = CNT_W + lrd_pkg::PIX_W;

    logic [SUM_W-1:0] sum_b_reg, sum_b_next;
    logic [SUM_W-1:0] sum_g_reg, sum_g_next;
    logic [SUM_W-1:0] sum_r_reg, sum_r_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_b_add, sum_g_add, sum_r_add;
    logic [CNT_W-1:0] count_add;
    logic             room;
    logic             close;

    // Pixels beyond the column limit are dropped from the row totals.
    assign room  = (count_reg < CNT_W'(MAX_COLS));
    assign close = row_end || frame_end;

    assign sum_b_add = room ? sum_b_reg + SUM_W'(blue)  : sum_b_reg;
    assign sum_g_add = room ? sum_g_reg + SUM_W'(green) : sum_g_reg;
    assign sum_r_add = room ? sum_r_reg + SUM_W'(red)   : sum_r_reg;
    assign count_add = room ? count_reg + 1'b1 : count_reg;

    assign rec_push = accept && close;
    assign rec_data = {frame_end, count_add, sum_r_add, sum_g_add, sum_b_add};

    always_comb
    begin
        sum_b_next = sum_b_reg;
        sum_g_next = sum_g_reg;
        sum_r_next = sum_r_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (close)
            begin
                sum_b_next = '0;
                sum_g_next = '0;
                sum_r_next = '0;
                count_next = '0;
            end
            else
            begin
                sum_b_next = sum_b_add;
                sum_g_next = sum_g_add;
                sum_r_next = sum_r_add;
                count_next = count_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_b_reg <= '0;
            sum_g_reg <= '0;
            sum_r_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_b_reg <= sum_b_next;
            sum_g_reg <= sum_g_next;
            sum_r_reg <= sum_r_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lrd_back.sv @@
`default_nettype none

module lrd_back #(
    parameter int MAX_COLS = 4096,
    parameter int MAX_ROWS = 2048
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [lrd_pkg::BRIGHT_W-1:0] threshold,
    input  wire logic                         rec_empty,
    input  wire logic [3*($clog2(MAX_COLS+1)+lrd_pkg::PIX_W)+$clog2(MAX_COLS+1):0] rec_data,
    output logic                              rec_pop,
    input  wire logic                         res_full,
    output logic                              res_push,
    output lrd_pkg::result_t                  res_data
);

    localparam int CNT_W = $clog2(MAX_COLS + 1);
    localparam int SUM_W = CNT_W + lrd_pkg::PIX_W;
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int EXT_W = lrd_pkg::TOP_W + 1;

    lrd_pkg::bk_state_t state_reg, state_next;

    logic [SUM_W-1:0]                 rem_reg [3];
    logic [SUM_W-1:0]                 rem_next [3];
    logic [lrd_pkg::QUO_W-1:0]        quo_reg [3];
    logic [lrd_pkg::QUO_W-1:0]        quo_next [3];
    logic [SUM_W-1:0]                 trial;
    logic [CNT_W-1:0]                 div_reg;
    logic [lrd_pkg::QBIT_W-1:0]       bit_reg;
    logic                             last_reg;
    logic [lrd_pkg::TOTAL_W-1:0]      total_reg;
    logic [lrd_pkg::PROD_W-1:0]       prod;
    logic [lrd_pkg::BRIGHT_W-1:0]     bright_reg;

    logic [ROW_W-1:0]                 row_reg;
    logic [lrd_pkg::BRIGHT_W-1:0]     prev_reg;
    logic                             top_seen_reg, top_seen_next;
    logic                             bot_seen_reg, bot_seen_next;
    logic [lrd_pkg::TOP_W-1:0]        top_line_reg, top_line_next;
    logic [lrd_pkg::BOT_W-1:0]        bot_line_reg, bot_line_next;
    logic [EXT_W-1:0]                 row_ext;
    logic                             dark;
    logic                             prev_dark;
    logic                             upd_done;
    logic                             load;

    // One quotient bit per cycle for all three channels, most significant first.
    assign trial = SUM_W'(div_reg) << bit_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            rem_next[c] = rem_reg[c];
            quo_next[c] = quo_reg[c];
            if (rem_reg[c] >= trial)
            begin
                rem_next[c]          = rem_reg[c] - trial;
                quo_next[c][bit_reg] = 1'b1;
            end
        end
    end

    assign prod = lrd_pkg::PROD_W'(total_reg) * lrd_pkg::PROD_W'(lrd_pkg::DIV3_MUL);

    // Edge detection on the finished row.
    assign dark      = (bright_reg <= threshold);
    assign prev_dark = (prev_reg <= threshold);
    assign row_ext   = EXT_W'(row_reg);

    always_comb
    begin
        top_seen_next = top_seen_reg;
        bot_seen_next = bot_seen_reg;
        top_line_next = top_line_reg;
        bot_line_next = bot_line_reg;
        if (!top_seen_reg)
        begin
            if (prev_dark && !dark)
            begin
                top_seen_next = 1'b1;
                top_line_next = lrd_pkg::TOP_W'(row_ext - 1'b1);
            end
        end
        else if (!prev_dark && dark)
        begin
            bot_seen_next = 1'b1;
            bot_line_next = lrd_pkg::BOT_W'(row_ext);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lrd_pkg::BK_IDLE:
            begin
                if (!rec_empty)
                begin
                    state_next = lrd_pkg::BK_DIV;
                end
            end
            lrd_pkg::BK_DIV:
            begin
                if (bit_reg == '0)
                begin
                    state_next = lrd_pkg::BK_ADD;
                end
            end
            lrd_pkg::BK_ADD:
            begin
                state_next = lrd_pkg::BK_MUL;
            end
            lrd_pkg::BK_MUL:
            begin
                state_next = lrd_pkg::BK_UPD;
            end
            lrd_pkg::BK_UPD:
            begin
                if (upd_done)
                begin
                    state_next = lrd_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = lrd_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        load     = (state_reg == lrd_pkg::BK_IDLE) && !rec_empty;
        upd_done = (state_reg == lrd_pkg::BK_UPD) && (!last_reg || !res_full);
        rec_pop  = load;
        res_push = upd_done && last_reg;
        res_data.top_found    = top_seen_next;
        res_data.top_row      = top_line_next;
        res_data.bottom_found = bot_seen_next;
        res_data.bottom_row   = bot_line_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lrd_pkg::BK_IDLE;
            row_reg      <= '0;
            prev_reg     <= '0;
            top_seen_reg <= 1'b0;
            bot_seen_reg <= 1'b0;
            top_line_reg <= '0;
            bot_line_reg <= '0;
            bit_reg      <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                bit_reg  <= lrd_pkg::QBIT_W'(lrd_pkg::QUO_W - 1);
                last_reg <= rec_data[3*SUM_W+CNT_W];
            end
            else if (state_reg == lrd_pkg::BK_DIV)
            begin
                bit_reg <= bit_reg - 1'b1;
            end
            if (upd_done)
            begin
                if (last_reg)
                begin
                    row_reg      <= '0;
                    prev_reg     <= '0;
                    top_seen_reg <= 1'b0;
                    bot_seen_reg <= 1'b0;
                    top_line_reg <= '0;
                    bot_line_reg <= '0;
                end
                else
                begin
                    prev_reg     <= bright_reg;
                    top_seen_reg <= top_seen_next;
                    bot_seen_reg <= bot_seen_next;
                    top_line_reg <= top_line_next;
                    bot_line_reg <= bot_line_next;
                    if (row_reg < ROW_W'(MAX_ROWS - 1))
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg[0] <= rec_data[SUM_W-1:0];
            rem_reg[1] <= rec_data[2*SUM_W-1:SUM_W];
            rem_reg[2] <= rec_data[3*SUM_W-1:2*SUM_W];
            div_reg    <= rec_data[3*SUM_W+CNT_W-1:3*SUM_W];
            for (int c = 0; c < 3; c++)
            begin
                quo_reg[c] <= '0;
            end
        end
        else if (state_reg == lrd_pkg::BK_DIV)
        begin
            for (int c = 0; c < 3; c++)
            begin
                rem_reg[c] <= rem_next[c];
                quo_reg[c] <= quo_next[c];
            end
        end
        if (state_reg == lrd_pkg::BK_ADD)
        begin
            total_reg <= lrd_pkg::TOTAL_W'(quo_reg[0]) + lrd_pkg::TOTAL_W'(quo_reg[1])
                       + lrd_pkg::TOTAL_W'(quo_reg[2]);
        end
        if (state_reg == lrd_pkg::BK_MUL)
        begin
            bright_reg <= lrd_pkg::BRIGHT_W'(prod >> lrd_pkg::DIV3_SHIFT);
        end
    end

endmodule

`default_nettype wire

@@ rtl/letterbox_row_detector_core.sv @@
// Letterbox row detector: finds where the dark bars above and below a picture end.
// Input channel: pixels (blue, green, red, row_end, frame_end) are pushed as beats
// with push/full; a beat is taken when push is high and full is low. The front
// part accumulates channel sums at one pixel per cycle and hands each finished row
// to a two-entry row queue; full rises only while that queue holds two rows.
// The back part evaluates each row in steps: a load, the shared bit-per-cycle
// quotient unit (three channel means at once), an add, a divide by three and an
// edge update. Rows no shorter than that evaluation stream at one pixel per clock;
// shorter rows are limited by it. Result channel: one beat per frame (top_found,
// top_row, bottom_found, bottom_row), read with empty/pop from a two-entry result
// queue. Empty falls once the frame's last row has passed those steps, if the back
// part was free. If the receiver stalls, results wait in the queue; the back part
// then holds its final row, the row queue fills and full rises, while accepted
// beats are never lost. Threshold: written over cfg_valid/cfg_ready (always ready);
// the user must write it only while the block is idle, which the block does not
// enforce. Reset clears the threshold, all row and frame state and both queues.
`default_nettype none

module letterbox_row_detector_core #(
    parameter int MAX_COLS = 4096,
    parameter int MAX_ROWS = 2048
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [lrd_pkg::PIX_W-1:0]    blue,
    input  wire logic [lrd_pkg::PIX_W-1:0]    green,
    input  wire logic [lrd_pkg::PIX_W-1:0]    red,
    input  wire logic                         row_end,
    input  wire logic                         frame_end,
    output logic                              empty,
    input  wire logic                         pop,
    output logic                              top_found,
    output logic signed [lrd_pkg::TOP_W-1:0]  top_row,
    output logic                              bottom_found,
    output logic [lrd_pkg::BOT_W-1:0]         bottom_row,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [lrd_pkg::BRIGHT_W-1:0] threshold
);

    // A row record carries the three channel sums, the pixel count and the
    // frame-end mark.
    localparam int CNT_W = $clog2(MAX_COLS + 1);
    localparam int SUM_W = CNT_W + lrd_pkg::PIX_W;
    localparam int REC_W = 3 * SUM_W + CNT_W + 1;
    localparam int RES_W = $bits(lrd_pkg::result_t);

    logic [lrd_pkg::BRIGHT_W-1:0] threshold_reg;
    logic                         accept;
    logic                         rec_push;
    logic [REC_W-1:0]             rec_wdata;
    logic [REC_W-1:0]             rec_rdata;
    logic                         rec_full;
    logic                         rec_empty;
    logic                         rec_pop;
    logic                         res_push;
    logic                         res_full;
    lrd_pkg::result_t             res_wdata;
    lrd_pkg::result_t             res_rdata;

    assign cfg_ready = 1'b1;
    assign full      = rec_full;
    assign accept    = push && !rec_full;

    // The threshold is sampled by the back part when it judges each row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            threshold_reg <= threshold;
        end
    end

    lrd_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .blue      (blue),
        .green     (green),
        .red       (red),
        .row_end   (row_end),
        .frame_end (frame_end),
        .rec_push  (rec_push),
        .rec_data  (rec_wdata)
    );

    lrd_fifo #(
        .WIDTH (REC_W),
        .DEPTH (2)
    ) u_row_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_push),
        .wr_data (rec_wdata),
        .full    (rec_full),
        .rd_en   (rec_pop),
        .rd_data (rec_rdata),
        .empty   (rec_empty)
    );

    lrd_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (threshold_reg),
        .rec_empty (rec_empty),
        .rec_data  (rec_rdata),
        .rec_pop   (rec_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_wdata)
    );

    lrd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_wdata),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rdata),
        .empty   (empty)
    );

    assign top_found    = res_rdata.top_found;
    assign top_row      = res_rdata.top_row;
    assign bottom_found = res_rdata.bottom_found;
    assign bottom_row   = res_rdata.bottom_row;

endmodule

`default_nettype wire

@@ rtl/lrd_checker.sv @@
`default_nettype none

module lrd_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         empty,
    input wire logic                         pop,
    input wire logic                         top_found,
    input wire logic [lrd_pkg::TOP_W-1:0]    top_row,
    input wire logic                         bottom_found,
    input wire logic [lrd_pkg::BOT_W-1:0]    bottom_row
);

    // A waiting result beat holds until it is taken.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(top_found) && $stable(top_row)
                              && $stable(bottom_found) && $stable(bottom_row)))
        else $error("result beat changed while stalled");

    // A bottom edge is only searched for once the top edge is known.
    a_bottom_after_top: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && bottom_found) |-> top_found)
        else $error("bottom edge reported without a top edge");

    a_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !top_found) |-> (top_row == '0))
        else $error("top row nonzero while top not found");

    a_bottom_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !bottom_found) |-> (bottom_row == '0))
        else $error("bottom row nonzero while bottom not found");

endmodule

bind letterbox_row_detector_core lrd_checker u_lrd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .top_found    (top_found),
    .top_row      (top_row),
    .bottom_found (bottom_found),
    .bottom_row   (bottom_row)
);

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

// Self-checking bench for the letterbox row detector. Pixel beats are driven
// on the falling clock edge and every handshake is sampled on the rising edge.
// Each accepted pixel beat feeds a bar tracker inside the bench, which keeps
// its own copy of the row sums, the row counter, the edge flags and the
// threshold. When a frame closes, the tracker queues the result beat that the
// block must produce. A separate process pops result beats at random and
// compares each one, field by field, with the oldest queued expectation.
module tb;

    // Geometry limits. The block is built with the same values.
    localparam int COLS = 4096;
    localparam int ROWS = 2048;

    localparam int RESET_CYCLES = 11;

    // A settling pause, kept after the last expected beat, before a threshold write
    // and at the end.
    localparam int SETTLE_CYCLES = 40;

    // The slowest correct traffic is one-pixel rows, one row evaluation each; this
    // limit is meant to lie far above that even with random stalls.
    localparam int QUIET_LIMIT = 2000;

    // Idle percentages that the random phases use.
    localparam int NO_IDLE    = 0;
    localparam int HEAVY_IDLE = 48;
    localparam int LIGHT_IDLE = 6;

    // Random pixel beats in each of the four idling phases.
    localparam int PHASE_ITEMS = 370;
    localparam int PHASE_MIN_FRAMES = 12;

    // The threshold is rewritten every few random frames.
    localparam int FRAMES_PER_THRESHOLD = 6;

    typedef struct packed {
        logic [lrd_pkg::PIX_W-1:0] blue;
        logic [lrd_pkg::PIX_W-1:0] green;
        logic [lrd_pkg::PIX_W-1:0] red;
        logic                      row_end;
        logic                      frame_end;
    } pixel_beat_t;

    // Every input is driven to a known value from time zero.
    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             push = 1'b0;
    logic                             full;
    logic [lrd_pkg::PIX_W-1:0]        blue = '0;
    logic [lrd_pkg::PIX_W-1:0]        green = '0;
    logic [lrd_pkg::PIX_W-1:0]        red = '0;
    logic                             row_end = 1'b0;
    logic                             frame_end = 1'b0;
    logic                             empty;
    logic                             pop = 1'b0;
    logic                             top_found;
    logic signed [lrd_pkg::TOP_W-1:0] top_row;
    logic                             bottom_found;
    logic [lrd_pkg::BOT_W-1:0]        bottom_row;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [lrd_pkg::BRIGHT_W-1:0]     threshold = '0;

    // Idle control for both sides of the block.
    int gap_pct = NO_IDLE;
    int stall_pct = NO_IDLE;

    int mismatches = 0;
    int pixels_sent = 0;
    int quiet_cycles = 0;

    // Result beats that the bar tracker has predicted and that have not been
    // popped yet, oldest first.
    lrd_pkg::result_t expected_edges[$];

    // Bar tracker state: the bench's own copy of the block's frame state.
    logic [lrd_pkg::BRIGHT_W-1:0] thr_model = '0;
    int unsigned                  acc_blue;
    int unsigned                  acc_green;
    int unsigned                  acc_red;
    int unsigned                  row_pixels;
    logic [lrd_pkg::BOT_W-1:0]    row_index;
    logic [lrd_pkg::BRIGHT_W-1:0] last_level;
    logic                         top_hit;
    logic                         bottom_hit;
    logic [lrd_pkg::TOP_W-1:0]    top_mark;
    logic [lrd_pkg::BOT_W-1:0]    bottom_mark;

    letterbox_row_detector_core #(
        .MAX_COLS(COLS),
        .MAX_ROWS(ROWS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .blue(blue),
        .green(green),
        .red(red),
        .row_end(row_end),
        .frame_end(frame_end),
        .empty(empty),
        .pop(pop),
        .top_found(top_found),
        .top_row(top_row),
        .bottom_found(bottom_found),
        .bottom_row(bottom_row),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .threshold(threshold)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ERROR: %s", $time, what);
        mismatches++;
    endtask

    // Clears everything that belongs to one frame. The threshold survives.
    function automatic void clear_frame();
        acc_blue = 0;
        acc_green = 0;
        acc_red = 0;
        row_pixels = 0;
        row_index = '0;
        last_level = '0;
        top_hit = 1'b0;
        bottom_hit = 1'b0;
        top_mark = '0;
        bottom_mark = '0;
    endfunction

    // Advances the bar tracker by one accepted pixel beat. When the beat closes
    // a frame, the predicted result beat is queued.
    function automatic void track_bars(input pixel_beat_t px);
        int unsigned      level;
        lrd_pkg::result_t edges;
        // Pixels past the column limit are dropped, but their row end still counts.
        if (row_pixels < COLS)
        begin
            acc_blue += 32'(px.blue);
            acc_green += 32'(px.green);
            acc_red += 32'(px.red);
            row_pixels++;
        end
        if (!(px.row_end || px.frame_end))
            return;
        // The closing pixel is counted unless the row is already full, so the divisor is at least one.
        level = (acc_blue / row_pixels + acc_green / row_pixels + acc_red / row_pixels) / 3;
        if (!top_hit)
        begin
            // The first rise above the threshold marks the row before it; on
            // row 0 that wraps to -1 in twelve bits.
            if (last_level <= thr_model && level > 32'(thr_model))
            begin
                top_mark = {1'b0, row_index} - 12'd1;
                top_hit = 1'b1;
            end
        end
        else if (last_level > thr_model && level <= 32'(thr_model))
        begin
            // Every later fall overwrites the bottom mark, so the last one wins.
            bottom_mark = row_index;
            bottom_hit = 1'b1;
        end
        last_level = level[lrd_pkg::BRIGHT_W-1:0];
        acc_blue = 0;
        acc_green = 0;
        acc_red = 0;
        row_pixels = 0;
        // Rows past the row limit keep the last row number.
        if (row_index < lrd_pkg::BOT_W'(ROWS - 1))
            row_index++;
        if (!px.frame_end)
            return;
        edges.top_found = top_hit;
        edges.top_row = top_mark;
        edges.bottom_found = bottom_hit;
        edges.bottom_row = bottom_mark;
        expected_edges.push_back(edges);
        clear_frame();
    endfunction

    // Sends one pixel beat. The sender may idle first, then push is held high
    // until full is seen low at a rising edge. Push stays high on return so
    // that back-to-back beats flow without a gap.
    task automatic send_pixel(input pixel_beat_t px);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        blue <= px.blue;
        green <= px.green;
        red <= px.red;
        row_end <= px.row_end;
        frame_end <= px.frame_end;
        do
            @(posedge clk);
        while (full !== 1'b0);
        track_bars(px);
        pixels_sent++;
    endtask

    // Sends a row of pixels whose channels are drawn from lo to hi. With lo
    // equal to hi the row has an exact brightness. The last pixel carries the
    // row end if asked and the frame end if this is the last row.
    task automatic send_row(input int width, input int lo, input int hi,
                            input bit last_row, input bit mark_row_end);
        pixel_beat_t px;
        for (int i = 0; i < width; i++)
        begin
            px.blue = lrd_pkg::PIX_W'($urandom_range(hi, lo));
            px.green = lrd_pkg::PIX_W'($urandom_range(hi, lo));
            px.red = lrd_pkg::PIX_W'($urandom_range(hi, lo));
            px.row_end = (i == width - 1) && mark_row_end;
            px.frame_end = (i == width - 1) && last_row;
            send_pixel(px);
        end
    endtask

    // Stops sending and waits until every predicted result beat has been
    // popped, then lets the block settle.
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (expected_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the threshold while the block is idle.
    task automatic set_threshold(input int value);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        threshold <= value[lrd_pkg::BRIGHT_W-1:0];
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        thr_model = value[lrd_pkg::BRIGHT_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One-pixel frames: a dark frame finds nothing, a bright row 0 gives a top
    // of -1, and a frame end without a row end still closes the row.
    task automatic test_tiny_frames();
        set_threshold(0);
        send_row(1, 0, 0, 1'b1, 1'b1);
        send_row(1, 1, 1, 1'b1, 1'b1);
        send_pixel(pixel_beat_t'{8'hFF, 8'h00, 8'h00, 1'b0, 1'b1});
    endtask

    // Channel means are truncated before they are added, and the total is
    // truncated again by the divide by three.
    task automatic test_truncation();
        set_threshold(0);
        send_pixel(pixel_beat_t'{8'd1, 8'd1, 8'd1, 1'b0, 1'b0});
        send_pixel(pixel_beat_t'{8'd0, 8'd0, 8'd0, 1'b1, 1'b0});
        send_pixel(pixel_beat_t'{8'd3, 8'd0, 8'd0, 1'b0, 1'b0});
        send_pixel(pixel_beat_t'{8'd0, 8'd0, 8'd0, 1'b1, 1'b0});
        send_pixel(pixel_beat_t'{8'd2, 8'd2, 8'd0, 1'b0, 1'b0});
        send_pixel(pixel_beat_t'{8'd2, 8'd2, 8'd0, 1'b1, 1'b1});
    endtask

    // A classic letterbox: two bar rows, two picture rows, two bar rows. A row
    // exactly at the threshold counts as a bar.
    task automatic test_letterbox_edges();
        set_threshold(100);
        send_row(2, 100, 100, 1'b0, 1'b1);
        send_row(2, 0, 0, 1'b0, 1'b1);
        send_row(2, 101, 101, 1'b0, 1'b1);
        send_row(2, 255, 255, 1'b0, 1'b1);
        send_row(2, 100, 100, 1'b0, 1'b1);
        send_row(2, 0, 0, 1'b1, 1'b1);
    endtask

    // At the top threshold nothing is ever bright; a lower threshold with two
    // falls keeps the last one, and the frame closes on a bare frame end.
    task automatic test_threshold_extremes();
        set_threshold(255);
        send_row(2, 255, 255, 1'b1, 1'b1);
        set_threshold(50);
        send_row(1, 51, 51, 1'b0, 1'b1);
        send_row(1, 50, 50, 1'b0, 1'b1);
        send_row(1, 200, 200, 1'b0, 1'b1);
        send_row(1, 0, 0, 1'b1, 1'b0);
    endtask

    // One random frame. Most frames are letterboxed: bar rows above and below
    // picture rows, with content drawn so that every row lands on the intended
    // side of the threshold, often exactly on it or one above. Now and then a
    // row is flipped to give extra rises and falls. The rest are pure noise.
    task automatic send_random_frame();
        int width;
        int height;
        int top_bars;
        int bottom_bars;
        int thr_now;
        int pick;
        int lo;
        int hi;
        bit letterbox;
        bit dark;
        bit last_row;
        thr_now = int'(thr_model);
        width = ($urandom_range(19) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        height = $urandom_range(10, 1);
        letterbox = $urandom_range(9) < 8;
        top_bars = $urandom_range(height / 2);
        bottom_bars = $urandom_range(height / 2);
        for (int row = 0; row < height; row++)
        begin
            last_row = (row == height - 1);
            dark = (row < top_bars) || (row >= height - bottom_bars);
            if ($urandom_range(9) == 0)
                dark = !dark;
            if (!letterbox)
            begin
                lo = 0;
                hi = 255;
            end
            else if (dark || thr_now == 255)
            begin
                // Channels no higher than pick keep the row at or below it.
                pick = $urandom_range(1) ? thr_now : $urandom_range(thr_now);
                lo = $urandom_range(1) ? pick : 0;
                hi = pick;
            end
            else
            begin
                // Channels no lower than pick keep the row at or above it.
                pick = $urandom_range(1) ? thr_now + 1 : $urandom_range(255, thr_now + 1);
                lo = pick;
                hi = $urandom_range(1) ? pick : 255;
            end
            // The last row sometimes ends on the frame end alone.
            send_row(width, lo, hi, last_row, !(last_row && $urandom_range(3) == 0));
        end
    endtask

    // Random frames under one idling setting, with threshold rewrites that
    // hit both extremes now and then.
    task automatic test_random_traffic(input int gap, input int stall, input int items);
        int first_pixel;
        int frames;
        gap_pct = gap;
        stall_pct = stall;
        first_pixel = pixels_sent;
        frames = 0;
        while (pixels_sent - first_pixel < items || frames < PHASE_MIN_FRAMES)
        begin
            if (frames % FRAMES_PER_THRESHOLD == 0)
                set_threshold(($urandom_range(3) == 0) ? ($urandom_range(1) ? 255 : 0)
                                                       : $urandom_range(255));
            send_random_frame();
            frames++;
        end
    endtask

    // The receiver pops at random; a stall percentage of zero pops every cycle.
    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= stall_pct);

    // Each popped result beat is checked against the oldest prediction.
    always @(posedge clk)
    begin
        lrd_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_edges.size() == 0)
                report_mismatch("result beat with no frame outstanding");
            else
            begin
                want = expected_edges.pop_front();
                if (top_found !== want.top_found)
                    report_mismatch($sformatf("top_found %0b, want %0b",
                                              top_found, want.top_found));
                if (top_row !== want.top_row)
                    report_mismatch($sformatf("top_row %0d, want %0d",
                                              top_row, want.top_row));
                if (bottom_found !== want.bottom_found)
                    report_mismatch($sformatf("bottom_found %0b, want %0b",
                                              bottom_found, want.bottom_found));
                if (bottom_row !== want.bottom_row)
                    report_mismatch($sformatf("bottom_row %0d, want %0d",
                                              bottom_row, want.bottom_row));
            end
        end
    end

    // Watchdog: any handshake on any channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("letterbox_row_detector_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        clear_frame();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed checks run with both sides always ready.
        test_tiny_frames();
        test_truncation();
        test_letterbox_edges();
        test_threshold_extremes();

        // Random traffic under each idling setting in turn.
        test_random_traffic(NO_IDLE, NO_IDLE, PHASE_ITEMS);
        test_random_traffic(HEAVY_IDLE, NO_IDLE, PHASE_ITEMS);
        test_random_traffic(NO_IDLE, HEAVY_IDLE, PHASE_ITEMS);
        test_random_traffic(LIGHT_IDLE, LIGHT_IDLE, PHASE_ITEMS);

        drain();
        if (mismatches == 0)
            $display("letterbox_row_detector_core: match");
        else
            $display("letterbox_row_detector_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
